FILE: src/pmma_pkg.sv
// shared types and constants for the power meter moving average block
package pmma_pkg;

  localparam int VOLT_W      = 16;
  localparam int CURR_W      = 16;
  localparam int PROD_W      = 32;
  localparam int POWER_W     = 36;
  localparam int KW_W        = 16;
  localparam int BAR_OUT_W   = 5;

  // milliwatts per kilowatt and the bits it needs
  localparam int MW_PER_KW   = 1000000;
  localparam int MW_PER_KW_W = 20;

  // power / 1e6 as (power >> 6) / 15625, done by a reciprocal multiply;
  // exact for every 36-bit power
  localparam int                    KW_PRE_SHIFT   = 6;
  localparam int                    KW_RECIP_W     = 31;
  localparam logic [KW_RECIP_W-1:0] KW_RECIP       = 31'd1125899907;
  localparam int                    KW_RECIP_SHIFT = 44;

  localparam logic [POWER_W-1:0] FULL_SCALE_RESET = 36'd54000000;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               into_average;
  } pm_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_START,
    BK_WAIT
  } bk_state_t;

endpackage

FILE: src/pmma_ram.sv
// generic single-write, single-read ram with registered read data
module pmma_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/pmma_div.sv
// restoring divider, one quotient bit per cycle
module pmma_div #(
  parameter int N = 41,
  parameter int D = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D-1:0]     rem_r;
  logic [N-1:0]     quo_r;
  logic [D-1:0]     div_r;

  logic [D:0]       rem_sh;
  logic [D:0]       diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[N-1]};
    diff   = rem_sh - {1'b0, div_r};
    ge     = (rem_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[D-1:0] : rem_sh[D-1:0];
      quo_r <= {quo_r[N-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: src/pmma_front.sv
// front stage: takes samples, forms power in milliwatts, tags window entries
module pmma_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pmma_pkg::VOLT_W-1:0]   in_volts_dv,
  input  logic [pmma_pkg::CURR_W-1:0]   in_amps_da,
  input  logic                          in_into_average,
  output logic                          q_valid,
  input  logic                          q_ready,
  output pmma_pkg::pm_item_t            q_item
);

  import pmma_pkg::*;

  logic              s1_valid_r;
  logic [PROD_W-1:0] prod_r;
  logic              avg_r;
  logic [POWER_W-1:0] prod_ext;

  assign in_ready = !s1_valid_r || q_ready;
  assign q_valid  = s1_valid_r;

  // times ten as shift and add
  assign prod_ext = POWER_W'(prod_r);

  always_comb begin
    q_item.power        = (prod_ext << 3) + (prod_ext << 1);
    q_item.into_average = avg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r <= PROD_W'(in_volts_dv) * PROD_W'(in_amps_da);
      avg_r  <= in_into_average;
    end
  end

endmodule

FILE: src/pmma_queue.sv
// short queue between front and back
module pmma_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pmma_pkg::pm_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pmma_pkg::pm_item_t pop_item
);

  import pmma_pkg::*;

  pm_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/pmma_back.sv
// back end: window update, two parallel dividers, reciprocal multiply, output register
module pmma_back #(
  parameter int WINDOW_DEPTH = 16,
  parameter int BAR_WIDTH    = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  pmma_pkg::pm_item_t               q_item,
  input  logic [pmma_pkg::POWER_W-1:0]     full_scale,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pmma_pkg::KW_W-1:0]        out_instant_kw,
  output logic [pmma_pkg::KW_W-1:0]        out_average_kw,
  output logic [pmma_pkg::BAR_OUT_W-1:0]   out_bar_cells
);

  import pmma_pkg::*;

  localparam int PTR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W       = POWER_W + FILL_W;
  localparam int BAR_COEF_W  = $clog2(BAR_WIDTH + 1);
  localparam int BAR_PROD_W  = POWER_W + BAR_COEF_W;
  localparam int AVG_DIV_W   = MW_PER_KW_W + FILL_W;
  localparam int INST_X_W    = POWER_W - KW_PRE_SHIFT;
  localparam int INST_PROD_W = INST_X_W + KW_RECIP_W;

  bk_state_t          state_r, state_nxt;
  logic [POWER_W-1:0] power_r;
  logic               avg_r;
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KW_W-1:0]    inst_r;
  logic [KW_W-1:0]    avgkw_r;
  logic [BAR_OUT_W-1:0] bar_r;
  logic               load_out;
  logic               take_item;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [POWER_W-1:0] evict;

  logic               div_start;
  logic               avg_busy, bar_busy;
  logic [INST_PROD_W-1:0] inst_prod;
  logic [SUM_W-1:0]   avg_q;
  logic [BAR_PROD_W-1:0] bar_q;
  logic [BAR_PROD_W-1:0] bar_clamped;
  logic [AVG_DIV_W-1:0]  avg_divisor;
  logic [BAR_PROD_W-1:0] bar_dividend;
  logic [POWER_W-1:0]    fs_eff;

  pmma_ram #(
    .WIDTH (POWER_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wptr_r),
    .wr_data (power_r),
    .rd_en   (ram_rd_en),
    .rd_addr (wptr_r),
    .rd_data (evict)
  );

  // mean: sum / (fill * 1e6) equals the two nested truncating divisions
  assign avg_divisor  = AVG_DIV_W'(fill_r) * AVG_DIV_W'(MW_PER_KW);
  assign bar_dividend = BAR_PROD_W'(power_r) * BAR_PROD_W'(BAR_WIDTH);
  assign fs_eff       = (full_scale == '0) ? POWER_W'(1) : full_scale;

  // instant kilowatts: 30 x 31 bit multiply by the scaled reciprocal of 15625
  assign inst_prod = INST_PROD_W'(power_r[POWER_W-1:KW_PRE_SHIFT]) * INST_PROD_W'(KW_RECIP);

  pmma_div #(.N(SUM_W), .D(AVG_DIV_W)) u_div_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (avg_divisor),
    .busy     (avg_busy),
    .quotient (avg_q)
  );

  pmma_div #(.N(BAR_PROD_W), .D(POWER_W)) u_div_bar (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (bar_dividend),
    .divisor  (fs_eff),
    .busy     (bar_busy),
    .quotient (bar_q)
  );

  assign bar_clamped = (bar_q > BAR_PROD_W'(BAR_WIDTH)) ? BAR_PROD_W'(BAR_WIDTH) : bar_q;

  always_comb begin
    state_nxt     = state_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    q_ready       = 1'b0;
    take_item     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_wr_en     = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          take_item = 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        // fetch the slot that a full window evicts
        ram_rd_en = 1'b1;
        state_nxt = BK_UPDATE;
      end
      BK_UPDATE: begin
        if (avg_r) begin
          ram_wr_en = 1'b1;
          if (fill_r == FILL_W'(WINDOW_DEPTH)) begin
            sum_nxt = sum_r - SUM_W'(evict) + SUM_W'(power_r);
          end else begin
            sum_nxt  = sum_r + SUM_W'(power_r);
            fill_nxt = fill_r + 1'b1;
          end
          if (wptr_r == PTR_W'(WINDOW_DEPTH - 1)) begin
            wptr_nxt = '0;
          end else begin
            wptr_nxt = wptr_r + 1'b1;
          end
        end
        state_nxt = BK_START;
      end
      BK_START: begin
        div_start = 1'b1;
        state_nxt = BK_WAIT;
      end
      BK_WAIT: begin
        if (!avg_busy && !bar_busy && (!out_valid_r || out_ready)) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wptr_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      power_r <= q_item.power;
      avg_r   <= q_item.into_average;
    end
    if (load_out) begin
      inst_r  <= inst_prod[KW_RECIP_SHIFT +: KW_W];
      avgkw_r <= (fill_r == '0) ? '0 : avg_q[KW_W-1:0];
      bar_r   <= bar_clamped[BAR_OUT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_instant_kw = inst_r;
  assign out_average_kw = avgkw_r;
  assign out_bar_cells  = bar_r;

endmodule

FILE: src/power_meter_moving_average.sv
// top level of the power meter with moving average window and bar scaling
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in_      | in_valid / in_ready   | volts_dv[15:0], amps_da[15:0], into_average
//  out_     | out_valid / out_ready | instant_kw[15:0], average_kw[15:0], bar_cells[4:0]
//  cfg_     | cfg_valid / cfg_ready | full_scale_power_mw[35:0]
//
// one result per sample; the work on a sample is set by the two bit-serial
// dividers (mean and bar) that run side by side, each working through its
// dividend one bit at a time (41 bits for mean and bar with the default sizes),
// and by five back-end steps: take, window read, update, divider start and result load;
// instant kilowatts come from a combinational reciprocal multiply
// the front stage and a two-entry queue take the next samples while the back end works
// a finished result sits in the output register; the back end stalls only when
// it has a new one and that register is still waiting for its transfer
// reset (rst_n low, synchronous) empties the window, the queue and the output;
// the window ram needs no clearing pass, slots beyond the fill count are read but never used
module power_meter_moving_average #(
  parameter int WINDOW_DEPTH = 16,
  parameter int BAR_WIDTH    = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pmma_pkg::VOLT_W-1:0]    in_volts_dv,
  input  logic [pmma_pkg::CURR_W-1:0]    in_amps_da,
  input  logic                           in_into_average,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pmma_pkg::KW_W-1:0]      out_instant_kw,
  output logic [pmma_pkg::KW_W-1:0]      out_average_kw,
  output logic [pmma_pkg::BAR_OUT_W-1:0] out_bar_cells,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmma_pkg::POWER_W-1:0]   cfg_full_scale_power_mw
);

  import pmma_pkg::*;

  // full-scale register, written any time the port offers a transfer
  logic [POWER_W-1:0] full_scale_r;

  // front to queue
  logic     fq_valid;
  logic     fq_ready;
  pm_item_t fq_item;

  // queue to back
  logic     qb_valid;
  logic     qb_ready;
  pm_item_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      full_scale_r <= cfg_full_scale_power_mw;
    end
  end

  // front: product and times-ten scaling
  pmma_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_volts_dv     (in_volts_dv),
    .in_amps_da      (in_amps_da),
    .in_into_average (in_into_average),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_item          (fq_item)
  );

  // decoupling queue
  pmma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // back: window bookkeeping, division and result register
  pmma_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .BAR_WIDTH    (BAR_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_item         (qb_item),
    .full_scale     (full_scale_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_instant_kw (out_instant_kw),
    .out_average_kw (out_average_kw),
    .out_bar_cells  (out_bar_cells)
  );

  // every accepted sample shows up at the queue input in the next cycle
  a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> fq_valid)
    else $error("accepted sample did not reach the queue");

  // bar length never exceeds the bar width
  a_bar_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_bar_cells) <= 32'(BAR_WIDTH)))
    else $error("bar length above bar width");

  // the mean can never exceed the largest possible instant power
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average_kw <= 16'd42949))
    else $error("window mean out of range");

endmodule
